// ===== src/mfd_pkg.sv =====
package mfd_pkg;

  localparam int HEADER_SIZE_DEF   = 16;
  localparam int LENGTH_OFFSET_DEF = 8;

  localparam logic [7:0] SOI_BYTE0 = 8'hFF;
  localparam logic [7:0] SOI_BYTE1 = 8'hD8;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_MARK3      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MARK4      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIG_ENDIAN = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_FF    = 3'd1,
    PH_D8    = 3'd2,
    PH_M3    = 3'd3,
    PH_FRAME = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0]  mark3;
    logic [7:0]  mark4;
    logic        big_endian;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        error;
    logic [31:0] length;
  } result_t;

  typedef struct packed {
    logic single;
    logic burst;
  } emit_t;

endpackage

// ===== src/marked_frame_deframer.sv =====
// Marked frame deframer.
// Input channel (in_valid/in_ready/in_byte): one stream byte per transaction.
// Output channel (out_valid/out_ready/out_*): one frame byte per transaction,
// with out_last on the final byte, out_error with out_last when the header
// length is below the header size, and out_frame_length on the last byte.
// Config port (cfg_we/cfg_index/cfg_data): index 0 third mark byte, 1 fourth
// mark byte, 2 length byte order (0 little, 1 big); write only while idle.
// Path: a byte accepted is held in the input register, and its result is
// loaded into the output register once the output slot is free.
// Throughput: 1 byte per cycle while hunting and inside a frame, unless the
// receiver stalls. A completed start sequence gives four output transactions
// from one input byte; input waits while the output register replays them.
// Reset: hunting for the first start byte, config registers cleared, no
// output pending. When the receiver stalls, the output register holds and the
// input register fills, then in_ready drops until the output drains.
module marked_frame_deframer #(
  parameter int HEADER_SIZE   = mfd_pkg::HEADER_SIZE_DEF,
  parameter int LENGTH_OFFSET = mfd_pkg::LENGTH_OFFSET_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_last,
  output logic                            out_error,
  output logic [31:0]                     out_frame_length,
  input  logic                            cfg_we,
  input  logic [mfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mfd_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r, s1_byte_nxt;
  logic       slot_free;
  logic       core_fire;
  emit_t      emit;
  result_t    res;
  result_t    out_res;

  assign core_fire = s1_valid_r && slot_free;
  assign in_ready  = !s1_valid_r || core_fire;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MARK3:      cfg_nxt.mark3      = cfg_data;
        CFG_MARK4:      cfg_nxt.mark4      = cfg_data;
        CFG_BIG_ENDIAN: cfg_nxt.big_endian = cfg_data[0];
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
      s1_byte_nxt  = in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      cfg_r      <= cfg_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
  end

  mfd_core #(
    .HEADER_SIZE   (HEADER_SIZE),
    .LENGTH_OFFSET (LENGTH_OFFSET)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (core_fire),
    .in_data (s1_byte_r),
    .cfg     (cfg_r),
    .emit    (emit),
    .res     (res)
  );

  mfd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (core_fire),
    .emit      (emit),
    .res       (res),
    .mark3     (cfg_r.mark3),
    .tail      (s1_byte_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .slot_free (slot_free)
  );

  assign out_byte         = out_res.data;
  assign out_last         = out_res.last;
  assign out_error        = out_res.error;
  assign out_frame_length = out_res.length;

endmodule

// ===== src/mfd_core.sv =====
module mfd_core #(
  parameter int HEADER_SIZE   = mfd_pkg::HEADER_SIZE_DEF,
  parameter int LENGTH_OFFSET = mfd_pkg::LENGTH_OFFSET_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       in_data,
  input  mfd_pkg::cfg_t    cfg,
  output mfd_pkg::emit_t   emit,
  output mfd_pkg::result_t res
);
  import mfd_pkg::*;

  localparam logic [31:0] HS = 32'(HEADER_SIZE);
  localparam logic [31:0] LO = 32'(LENGTH_OFFSET);

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;

  logic [31:0] cnt_inc;
  logic [31:0] len_off;
  logic        len_win;
  logic [31:0] len_gath;
  logic        frame_last;
  logic        frame_err;

  // length gathering and end-of-frame decision
  always_comb begin
    cnt_inc  = cnt_r + 32'd1;
    len_off  = cnt_r - LO;
    len_win  = (cnt_r >= LO) && (len_off < 32'd4) && (cnt_r < HS);
    len_gath = len_r;
    if (len_win) begin
      if (cfg.big_endian) begin
        len_gath = {len_r[23:0], in_data};
      end else begin
        len_gath = len_r | ({24'd0, in_data} << {len_off[1:0], 3'b000});
      end
    end
    frame_last = 1'b0;
    frame_err  = 1'b0;
    if (cnt_inc == HS) begin
      if (len_gath <= HS) begin
        frame_last = 1'b1;
        frame_err  = (len_gath < HS);
      end
    end else if ((cnt_inc > HS) && (cnt_inc == len_gath)) begin
      frame_last = 1'b1;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    if (fire) begin
      unique case (phase_r)
        PH_FF: begin
          if (in_data == SOI_BYTE1) begin
            phase_nxt = PH_D8;
          end else if (in_data == SOI_BYTE0) begin
            phase_nxt = PH_FF;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_D8: begin
          phase_nxt = (in_data == cfg.mark3) ? PH_M3 : PH_HUNT;
        end
        PH_M3: begin
          if (in_data == cfg.mark4) begin
            phase_nxt = PH_FRAME;
            cnt_nxt   = 32'd4;
            len_nxt   = 32'd0;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_FRAME: begin
          len_nxt = len_gath;
          if (frame_last) begin
            phase_nxt = PH_HUNT;
            cnt_nxt   = 32'd0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: begin
          phase_nxt = (in_data == SOI_BYTE0) ? PH_FF : PH_HUNT;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    emit       = '0;
    res.data   = in_data;
    res.last   = 1'b0;
    res.error  = 1'b0;
    res.length = 32'd0;
    unique case (phase_r)
      PH_M3: begin
        emit.burst = fire && (in_data == cfg.mark4);
      end
      PH_FRAME: begin
        emit.single = fire;
        res.last    = frame_last;
        res.error   = frame_err;
        res.length  = frame_last ? len_gath : 32'd0;
      end
      default: begin
        emit = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cnt_r   <= 32'd0;
      len_r   <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

// ===== src/mfd_out.sv =====
module mfd_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  mfd_pkg::emit_t   emit,
  input  mfd_pkg::result_t res,
  input  logic [7:0]       mark3,
  input  logic [7:0]       tail,
  input  logic             out_ready,
  output logic             out_valid,
  output mfd_pkg::result_t out_res,
  output logic             slot_free
);
  import mfd_pkg::*;

  logic        valid_r, valid_nxt;
  logic [1:0]  burst_r, burst_nxt;
  result_t     res_r, res_nxt;
  logic [7:0]  mark3_r, mark3_nxt;
  logic [7:0]  tail_r, tail_nxt;

  assign slot_free = (burst_r == 2'd0) && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    burst_nxt = burst_r;
    res_nxt   = res_r;
    mark3_nxt = mark3_r;
    tail_nxt  = tail_r;
    if (valid_r && out_ready) begin
      if (burst_r != 2'd0) begin
        burst_nxt = burst_r - 2'd1;
        case (burst_r)
          2'd3:    res_nxt.data = SOI_BYTE1;
          2'd2:    res_nxt.data = mark3_r;
          default: res_nxt.data = tail_r;
        endcase
      end else begin
        valid_nxt = 1'b0;
      end
    end
    if (load && emit.single) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (load && emit.burst) begin
      valid_nxt = 1'b1;
      burst_nxt = 2'd3;
      res_nxt   = '{data: SOI_BYTE0, last: 1'b0, error: 1'b0, length: 32'd0};
      mark3_nxt = mark3;
      tail_nxt  = tail;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      burst_r <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      burst_r <= burst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    mark3_r <= mark3_nxt;
    tail_r  <= tail_nxt;
  end

endmodule

// ===== src/mfd_checker.sv =====
module mfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic        out_error,
  input logic [31:0] out_frame_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output changed while stalled");

  a_err_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last)
    else $error("error flag without last");

  a_len_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_frame_length == 32'd0)
    else $error("frame length shown on a non-final byte");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("output right after end of frame");

endmodule

bind marked_frame_deframer mfd_checker u_mfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_byte         (out_byte),
  .out_last         (out_last),
  .out_error        (out_error),
  .out_frame_length (out_frame_length)
);

// ===== dv/tb_marked_frame_deframer.sv =====
`timescale 1ns / 1ps

module tb_marked_frame_deframer;
  import mfd_pkg::*;

  class frame_tracker;
    phase_t      hunt;
    logic [31:0] count;
    logic [31:0] length;
    logic [7:0]  mark3;
    logic [7:0]  mark4;
    logic        big_endian;
    result_t     pending_bytes[$];
    int          mismatches;

    function new();
      hunt = PH_HUNT;
      count = '0;
      length = '0;
      mark3 = '0;
      mark4 = '0;
      big_endian = 1'b0;
      mismatches = 0;
    endfunction

    function void set_config(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_MARK3:      mark3 = val;
        CFG_MARK4:      mark4 = val;
        CFG_BIG_ENDIAN: big_endian = val[0];
        default: ;
      endcase
    endfunction

    function void push(logic [7:0] b, logic last, logic err, logic [31:0] len);
      result_t r;
      r.data = b;
      r.last = last;
      r.error = err;
      r.length = len;
      pending_bytes.insert(pending_bytes.size(), r);
    endfunction

    // Called once per accepted input transaction.
    function void accept_byte(logic [7:0] b);
      logic [31:0] c;
      logic        fin;
      case (hunt)
        PH_FF: begin
          if (b == SOI_BYTE1) hunt = PH_D8;
          else if (b == SOI_BYTE0) hunt = PH_FF;
          else hunt = PH_HUNT;
        end
        PH_D8: hunt = (b == mark3) ? PH_M3 : PH_HUNT;
        PH_M3: begin
          if (b == mark4) begin
            hunt = PH_FRAME;
            count = 32'd4;
            length = '0;
            push(SOI_BYTE0, 1'b0, 1'b0, '0);
            push(SOI_BYTE1, 1'b0, 1'b0, '0);
            push(mark3, 1'b0, 1'b0, '0);
            push(b, 1'b0, 1'b0, '0);
          end else begin
            hunt = PH_HUNT;
          end
        end
        PH_FRAME: begin
          if (count >= LENGTH_OFFSET_DEF && count - LENGTH_OFFSET_DEF < 4 &&
              count < HEADER_SIZE_DEF) begin
            if (big_endian) length = {length[23:0], b};
            else length = length | (32'(b) << (8 * (count - LENGTH_OFFSET_DEF)));
          end
          c = count + 32'd1;
          count = c;
          if (c == HEADER_SIZE_DEF) fin = (length <= HEADER_SIZE_DEF);
          else fin = (c > HEADER_SIZE_DEF) && (c == length);
          if (fin) begin
            push(b, 1'b1, length < HEADER_SIZE_DEF, length);
            hunt = PH_HUNT;
            count = '0;
          end else begin
            push(b, 1'b0, 1'b0, '0);
          end
        end
        default: hunt = (b == SOI_BYTE0) ? PH_FF : PH_HUNT;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $display("%0t unexpected output: expected none, got byte %h last %b error %b %s %h",
                 $time, got.data, got.last, got.error, "length", got.length);
        return;
      end
      want = pending_bytes[0];
      pending_bytes.delete(0);
      if (got !== want) begin
        mismatches++;
        $display("%0t mismatch: expected byte %h last %b error %b length %h,",
                 $time, want.data, want.last, want.error, want.length);
        $display("%0t   got byte %h last %b error %b length %h",
                 $time, got.data, got.last, got.error, got.length);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_byte = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             out_byte;
  logic                   out_last;
  logic                   out_error;
  logic [31:0]            out_frame_length;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  frame_tracker tracker = new();
  int           sent = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  marked_frame_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_error        (out_error),
    .out_frame_length (out_frame_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_result({out_byte, out_last, out_error, out_frame_length});
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    tracker.accept_byte(b);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending_bytes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] m3, input logic [7:0] m4, input logic be);
    logic [CFG_INDEX_W-1:0] idx[3];
    logic [7:0]             vals[3];
    idx = '{CFG_MARK3, CFG_MARK4, CFG_BIG_ENDIAN};
    vals = '{m3, m4, {7'd0, be}};
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      tracker.set_config(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input logic [31:0] len);
    int stop;
    int k;
    // open-ended length: send only a slice of the body
    if (len > 32'd1000) stop = 24;
    else stop = (len <= HEADER_SIZE_DEF) ? HEADER_SIZE_DEF : int'(len);
    send_byte(SOI_BYTE0);
    send_byte(SOI_BYTE1);
    send_byte(tracker.mark3);
    send_byte(tracker.mark4);
    for (int pos = 4; pos < stop; pos++) begin
      k = pos - LENGTH_OFFSET_DEF;
      if (k >= 0 && k < 4)
        send_byte(tracker.big_endian ? len[8*(3-k) +: 8] : len[8*k +: 8]);
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic send_broken();
    logic [7:0] seq[4];
    logic [7:0] bad;
    int         cut;
    seq = '{SOI_BYTE0, SOI_BYTE1, tracker.mark3, tracker.mark4};
    cut = $urandom_range(3, 1);
    for (int i = 0; i < cut; i++) send_byte(seq[i]);
    do bad = 8'($urandom_range(255)); while (bad == seq[cut]);
    send_byte(bad);
  endtask

  task automatic run_frames(input int target);
    int pick;
    while (sent < target) begin
      if ($urandom_range(99) < 15) send_broken();
      repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
      pick = $urandom_range(99);
      if (pick < 20) send_frame(32'($urandom_range(15)));
      else if (pick < 35) send_frame(HEADER_SIZE_DEF);
      else send_frame(32'($urandom_range(HEADER_SIZE_DEF + 12, HEADER_SIZE_DEF + 1)));
      if ($urandom_range(7) == 0) wait_drained();
    end
  endtask

  initial begin
    int         idle_tab[4];
    int         stall_tab[4];
    logic [7:0] lead[7];
    logic [7:0] tail[4];
    idle_tab = '{0, 45, 0, 29};
    stall_tab = '{0, 0, 45, 29};
    // FF D8 FF drops the hunt; FF FF then restarts on the second FF
    lead = '{8'hFF, 8'hD8, 8'hFF, 8'hD8, 8'h00, 8'hFF, 8'hFF};
    // fourth mark mismatch
    tail = '{8'hFF, 8'hD8, 8'h00, 8'h00};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = idle_tab[ph % 4];
      recv_stall_pct = stall_tab[ph % 4];
      case (ph)
        0: write_config(8'h00, 8'hFF, 1'b0);
        1: write_config(8'hFF, 8'h00, 1'b1);
        2: write_config(8'hD8, 8'hFF, 1'b0);
        3: write_config(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
        default: write_config(8'hFF, 8'hFF, 1'($urandom_range(1)));
      endcase
      if (ph == 0) begin
        foreach (lead[i]) send_byte(lead[i]);
        send_frame(32'd0);
        foreach (tail[i]) send_byte(tail[i]);
      end
      run_frames(60 * (ph + 1));
      if (ph == 4) send_frame(32'hFFFF_FFF0);
      wait_drained();
    end
    if (tracker.mismatches == 0 && tracker.pending_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
src/mfd_pkg.sv
src/mfd_core.sv
src/mfd_out.sv
src/marked_frame_deframer.sv
src/mfd_checker.sv
dv/tb_marked_frame_deframer.sv
